// ----- rtl/crtf_pkg.sv -----
// Shared types and constants of the code point range table filter.
package crtf_pkg;

  localparam int CP_W        = 16;
  localparam int IDX_IN_W    = 8;
  localparam int ENTRY_W     = 2 * CP_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int RC_W        = 9;
  localparam int ROW_CFG_W   = 7;

  localparam logic [CP_W-1:0] SPACE_CHAR = 16'h0020;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CHAR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBSTITUTE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_VIEW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_USE_WINDOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 3'd6;

  typedef logic [1:0] sel_t;
  localparam sel_t SEL_CP    = 2'd0;
  localparam sel_t SEL_SPACE = 2'd1;
  localparam sel_t SEL_END   = 2'd2;

  typedef struct packed {
    logic take_load;
    logic take_char;
    logic col_reduce;
    logic win_open_set;
    logic win_close_set;
    logic search_init;
    logic search_step;
    logic emit;
    sel_t emit_sel;
    logic col_inc;
    logic end_clear;
  } cmd_t;

  typedef struct packed {
    logic is_char;
    logic eos;
    logic col_ge_rw;
    logic col_zero;
    logic col_inc_zero;
    logic use_window;
    logic substitute;
    logic list_view;
    logic win_closed;
    logic open_nxt;
    logic above_high;
    logic cp_is_space;
    logic cnt_zero;
    logic hit;
    logic step_empty;
    logic slot_free;
  } stat_t;

endpackage

// ----- rtl/crtf_in_if.sv -----
// Input item channel: table loads and characters.
interface crtf_in_if import crtf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [IDX_IN_W-1:0] entry_index;
  logic [CP_W-1:0]     range_first;
  logic [CP_W-1:0]     range_final;
  logic [CP_W-1:0]     code_point;
  logic                end_of_string;

  modport source (output valid, command, entry_index, range_first, range_final,
                  code_point, end_of_string, input ready);
  modport sink (input valid, command, entry_index, range_first, range_final,
                code_point, end_of_string, output ready);
endinterface

// ----- rtl/crtf_out_if.sv -----
// Result item channel: emitted characters and end marker.
interface crtf_out_if import crtf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] char_out;
  logic            is_end;

  modport source (output valid, char_out, is_end, input ready);
  modport sink (input valid, char_out, is_end, output ready);
endinterface

// ----- rtl/crtf_cfg_if.sv -----
// Configuration register write channel.
interface crtf_cfg_if import crtf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/char_range_table_filter.sv -----
// Sequence: a load is written to the table from idle; a character is accepted, its column is
// fixed up, the mode is decided and, where needed, a binary search runs with one table read
// per step on the single read port, then emit (if any) and finish. A new item is accepted only
// in idle; padding spaces go out one per cycle while the output slot is free.
// Reset (rst_n, synchronous): config to defaults, column and window flags cleared,
// output empty; table contents stay undefined until loaded.
module char_range_table_filter import crtf_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_ROW     = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  crtf_in_if.sink    in_ch,
  crtf_out_if.source out_ch,
  crtf_cfg_if.sink   cfg_ch
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;
  logic  cfg_ready;
  logic  out_valid;
  logic [CP_W-1:0] out_char_out;
  logic  out_is_end;

  assign in_ch.ready     = in_ready;
  assign cfg_ch.ready    = cfg_ready;
  assign out_ch.valid    = out_valid;
  assign out_ch.char_out = out_char_out;
  assign out_ch.is_end   = out_is_end;

  crtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  crtf_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_ROW     (MAX_ROW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_ch.command),
    .in_entry_index   (in_ch.entry_index),
    .in_range_first   (in_ch.range_first),
    .in_range_final   (in_ch.range_final),
    .in_code_point    (in_ch.code_point),
    .in_end_of_string (in_ch.end_of_string),
    .cfg_valid        (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .cfg_ready        (cfg_ready),
    .out_ready        (out_ch.ready),
    .out_valid        (out_valid),
    .out_char_out     (out_char_out),
    .out_is_end       (out_is_end),
    .cmd              (cmd),
    .stat             (stat)
  );

endmodule

// ----- rtl/crtf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module crtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/crtf_datapath.sv -----
// Datapath: config registers, range table, search bounds, column, window flags, output register.
module crtf_datapath import crtf_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_ROW     = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_command,
  input  logic [IDX_IN_W-1:0]   in_entry_index,
  input  logic [CP_W-1:0]       in_range_first,
  input  logic [CP_W-1:0]       in_range_final,
  input  logic [CP_W-1:0]       in_code_point,
  input  logic                  in_end_of_string,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  cfg_ready,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [CP_W-1:0]       out_char_out,
  output logic                  out_is_end,
  input  cmd_t                  cmd,
  output stat_t                 stat
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SW    = CNT_W + 1;
  localparam int COL_W = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int RW_W  = $clog2(MAX_ROW + 1);

  logic [RC_W-1:0]      range_count_r;
  logic                 substitute_r;
  logic                 list_view_r;
  logic [ROW_CFG_W-1:0] row_width_r;
  logic                 use_window_r;
  logic [CP_W-1:0]      window_low_r;
  logic [CP_W-1:0]      window_high_r;

  logic [CP_W-1:0]      cp_r;
  logic                 eos_r;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic                 open_r, closed_r;

  logic signed [SW-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic [IDX_W-1:0]     mid_r, mid_nxt;

  logic                 out_valid_r;
  logic [CP_W-1:0]      out_char_r;
  logic                 out_end_r;

  logic [CNT_W-1:0]     cnt;
  logic [RW_W-1:0]      rw;
  logic [RW_W-1:0]      col_ext, col_p1;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic [CP_W-1:0]      first, final_cp;
  logic                 gt;
  logic signed [SW-1:0] hi_init, mid_s, lo_step, hi_step;
  logic [SW:0]          sum_init, sum_step;
  logic [IDX_W-1:0]     mid_init, mid_step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_count_r <= '0;
      substitute_r  <= 1'b0;
      list_view_r   <= 1'b0;
      row_width_r   <= ROW_CFG_W'(16);
      use_window_r  <= 1'b0;
      window_low_r  <= '0;
      window_high_r <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RANGE_COUNT: range_count_r <= cfg_data[RC_W-1:0];
        REG_SUBSTITUTE:  substitute_r  <= cfg_data[0];
        REG_LIST_VIEW:   list_view_r   <= cfg_data[0];
        REG_ROW_WIDTH:   row_width_r   <= cfg_data[ROW_CFG_W-1:0];
        REG_USE_WINDOW:  use_window_r  <= cfg_data[0];
        REG_WINDOW_LOW:  window_low_r  <= cfg_data;
        REG_WINDOW_HIGH: window_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective count and row width
  always_comb begin
    if (32'(range_count_r) > TABLE_DEPTH) begin
      cnt = CNT_W'(TABLE_DEPTH);
    end else begin
      cnt = CNT_W'(range_count_r);
    end
    if (row_width_r == '0) begin
      rw = RW_W'(1);
    end else if (32'(row_width_r) > MAX_ROW) begin
      rw = RW_W'(MAX_ROW);
    end else begin
      rw = RW_W'(row_width_r);
    end
  end

  // range table
  assign wr_en   = cmd.take_load && (32'(in_entry_index) < TABLE_DEPTH);
  assign wr_addr = IDX_W'(in_entry_index);

  crtf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ({in_range_first, in_range_final}),
    .rd_addr (mid_nxt),
    .rd_data (rd_data)
  );

  assign first    = rd_data[ENTRY_W-1:CP_W];
  assign final_cp = rd_data[CP_W-1:0];
  assign gt       = first < cp_r;

  // binary search bounds
  always_comb begin
    hi_init  = $signed({1'b0, cnt}) - SW'(1);
    sum_init = {hi_init[SW-1], hi_init};
    mid_init = sum_init[IDX_W:1];
    mid_s    = $signed({{(SW-IDX_W){1'b0}}, mid_r});
    lo_step  = gt ? mid_s + SW'(1) : lo_r;
    hi_step  = gt ? hi_r : mid_s - SW'(1);
    sum_step = {lo_step[SW-1], lo_step} + {hi_step[SW-1], hi_step};
    mid_step = sum_step[IDX_W:1];
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;
    mid_nxt  = mid_r;
    if (cmd.search_init) begin
      lo_nxt  = '0;
      hi_nxt  = hi_init;
      mid_nxt = mid_init;
    end else if (cmd.search_step) begin
      lo_nxt  = lo_step;
      hi_nxt  = hi_step;
      mid_nxt = mid_step;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    if (cmd.take_char) begin
      cp_r  <= in_code_point;
      eos_r <= in_end_of_string;
    end
  end

  // output column
  assign col_ext = RW_W'(col_r);
  assign col_p1  = col_ext + RW_W'(1);

  always_comb begin
    col_nxt = col_r;
    if (cmd.end_clear) begin
      col_nxt = '0;
    end else if (cmd.col_reduce) begin
      col_nxt = COL_W'(col_ext - rw);
    end else if (cmd.col_inc) begin
      col_nxt = (col_p1 == rw) ? '0 : COL_W'(col_p1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      open_r   <= 1'b0;
      closed_r <= 1'b0;
    end else begin
      col_r <= col_nxt;
      if (cmd.end_clear) begin
        open_r   <= 1'b0;
        closed_r <= 1'b0;
      end else begin
        if (cmd.win_open_set) begin
          open_r <= 1'b1;
        end
        if (cmd.win_close_set) begin
          closed_r <= 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        SEL_CP: begin
          out_char_r <= cp_r;
          out_end_r  <= 1'b0;
        end
        SEL_SPACE: begin
          out_char_r <= SPACE_CHAR;
          out_end_r  <= 1'b0;
        end
        SEL_END: begin
          out_char_r <= '0;
          out_end_r  <= 1'b1;
        end
        default: begin
          out_char_r <= '0;
          out_end_r  <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_is_end   = out_end_r;

  // status
  always_comb begin
    stat.is_char      = (in_command == CMD_CHAR);
    stat.eos          = eos_r;
    stat.col_ge_rw    = col_ext >= rw;
    stat.col_zero     = (col_r == '0);
    stat.col_inc_zero = (col_p1 == rw);
    stat.use_window   = use_window_r;
    stat.substitute   = substitute_r;
    stat.list_view    = list_view_r;
    stat.win_closed   = closed_r;
    stat.open_nxt     = open_r || (cp_r >= window_low_r);
    stat.above_high   = cp_r > window_high_r;
    stat.cp_is_space  = (cp_r == SPACE_CHAR);
    stat.cnt_zero     = (cnt == '0);
    stat.hit          = (cp_r >= first) && (cp_r <= final_cp);
    stat.step_empty   = lo_step > hi_step;
    stat.slot_free    = !out_valid_r || out_ready;
  end

endmodule

// ----- rtl/crtf_ctrl.sv -----
// Controller: per-item sequencing of column fix-up, mode decision, search, emit and padding.
module crtf_ctrl import crtf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_NORM   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_PAD    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_r, state_nxt;
  sel_t       sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_CP;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    logic go_search;
    logic miss_space;
    go_search  = 1'b0;
    miss_space = stat.use_window && stat.substitute && stat.list_view;
    cmd        = '0;
    state_nxt  = state_r;
    sel_nxt    = sel_r;
    in_ready   = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (stat.is_char) begin
            cmd.take_char = 1'b1;
            state_nxt     = S_NORM;
          end else begin
            cmd.take_load = 1'b1;
          end
        end
      end
      S_NORM: begin
        if (stat.col_ge_rw) begin
          cmd.col_reduce = 1'b1;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_FIN;
        if (stat.use_window) begin
          if (!stat.win_closed && stat.open_nxt) begin
            cmd.win_open_set = 1'b1;
            if (stat.above_high) begin
              cmd.win_close_set = 1'b1;
            end else begin
              go_search = 1'b1;
            end
          end
        end else if (!stat.substitute || !stat.cp_is_space) begin
          go_search = 1'b1;
        end else if (stat.list_view && !stat.col_zero) begin
          state_nxt = S_PAD;
        end
        if (go_search) begin
          cmd.search_init = 1'b1;
          if (!stat.cnt_zero) begin
            state_nxt = S_SEARCH;
          end else if (miss_space) begin
            sel_nxt   = SEL_SPACE;
            state_nxt = S_EMIT;
          end
        end
      end
      S_SEARCH: begin
        if (stat.hit) begin
          sel_nxt   = SEL_CP;
          state_nxt = S_EMIT;
        end else if (stat.step_empty) begin
          if (miss_space) begin
            sel_nxt   = SEL_SPACE;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = sel_r;
          cmd.col_inc  = 1'b1;
          state_nxt    = S_FIN;
        end
      end
      S_PAD: begin
        if (stat.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = SEL_SPACE;
          cmd.col_inc  = 1'b1;
          if (stat.col_inc_zero) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!stat.eos) begin
          state_nxt = S_IDLE;
        end else if (stat.slot_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = SEL_END;
          cmd.end_clear = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
